// ===== rtl/cvm_pkg.sv =====
package cvm_pkg;

	localparam int COL_W  = 12;
	localparam int ROW_W  = 12;
	localparam int CNT_W  = 13;
	localparam int VAL_W  = 16;
	localparam int PROD_W = 32;
	localparam int SUM_W  = 48;

	localparam int COL_SPAN     = 1 << COL_W;
	localparam int MAX_COLS_DEF = 4096;

	localparam int QUEUE_DEPTH = 4;
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_MATRIX = 1'b1;

	localparam logic [ADDR_W-3:0] REG_NUM_COLS  = 2'd0;
	localparam logic [ADDR_W-3:0] REG_START_COL = 2'd1;
	localparam logic [ADDR_W-3:0] REG_END_COL   = 2'd2;

	localparam logic [CNT_W-1:0] NUM_COLS_RST  = 13'd4096;
	localparam logic [COL_W-1:0] START_COL_RST = 12'd0;
	localparam logic [CNT_W-1:0] END_COL_RST   = 13'd4096;

	typedef struct packed {
		logic                    command;
		logic [ROW_W-1:0]        row_index;
		logic [COL_W-1:0]        col_index;
		logic signed [VAL_W-1:0] element_value;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0]        out_row;
		logic signed [SUM_W-1:0] row_sum;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] num_cols;
		logic [COL_W-1:0] start_col;
		logic [CNT_W-1:0] end_col;
	} cfg_t;

	typedef struct packed {
		logic                    mac;
		logic                    last;
		logic [ROW_W-1:0]        row;
		logic signed [VAL_W-1:0] elem;
		logic signed [VAL_W-1:0] vec;
	} op_t;

endpackage

// ===== rtl/cvm_stream_if.sv =====
interface cvm_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cvm_ram.sv =====
module cvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/cvm_fifo.sv =====
module cvm_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 4,
	parameter int  LW     = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_t         push_data,
	input  logic          pop,
	output item_t         pop_data,
	output logic          empty,
	output logic [LW-1:0] level
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign pop_data = mem_q[rd_ptr_q];
	assign empty    = (level_q == '0);
	assign level    = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + LW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== rtl/cvm_front.sv =====
module cvm_front #(
	parameter int MAX_COLS = cvm_pkg::MAX_COLS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	cvm_stream_if.sink               item,
	input  cvm_pkg::cfg_t            cfg,
	input  logic [cvm_pkg::LVL_W-1:0] q_level,
	output logic                     q_push,
	output cvm_pkg::op_t             q_push_data
);
	import cvm_pkg::*;

	localparam int STORE_DEPTH = (MAX_COLS > COL_SPAN) ? COL_SPAN : MAX_COLS;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CMP_W       = 18;

	logic             accept;
	logic             is_matrix;
	logic             in_store;
	logic             in_slice;
	logic             is_last;
	logic             take;
	logic [LVL_W:0]   credit;
	logic [COL_W-1:0] col;
	logic [VAL_W-1:0] vec_rd;

	logic                    f_valid_s1;
	logic                    f_mac_s1;
	logic                    f_last_s1;
	logic [ROW_W-1:0]        f_row_s1;
	logic signed [VAL_W-1:0] f_val_s1;

	// queue slots already claimed by the queue or by the stage in flight
	assign credit     = {1'b0, q_level} + {{LVL_W{1'b0}}, f_valid_s1};
	assign item.ready = (credit < (LVL_W + 1)'(QUEUE_DEPTH));
	assign accept     = item.valid && item.ready;

	assign col       = item.data.col_index;
	assign is_matrix = (item.data.command == CMD_MATRIX);
	assign in_store  = ({{(CMP_W - COL_W){1'b0}}, col} < CMP_W'(MAX_COLS));
	assign in_slice  = (col >= cfg.start_col) && ({1'b0, col} < cfg.end_col);
	assign is_last   = (cfg.num_cols != '0) && ({1'b0, col} == (cfg.num_cols - CNT_W'(1)));
	assign take      = accept && is_matrix && (in_slice || is_last);

	cvm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STORE_DEPTH),
		.AW    (STORE_AW)
	) u_store (
		.clk   (clk),
		.we    (accept && !is_matrix && in_store),
		.waddr (col[STORE_AW-1:0]),
		.wdata (item.data.element_value),
		.re    (accept && is_matrix && in_slice && in_store),
		.raddr (col[STORE_AW-1:0]),
		.rdata (vec_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s1 <= 1'b0;
		end else begin
			f_valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			f_mac_s1  <= in_slice && in_store;
			f_last_s1 <= is_last;
			f_row_s1  <= item.data.row_index;
			f_val_s1  <= item.data.element_value;
		end
	end

	assign q_push           = f_valid_s1;
	assign q_push_data.mac  = f_mac_s1;
	assign q_push_data.last = f_last_s1;
	assign q_push_data.row  = f_row_s1;
	assign q_push_data.elem = f_val_s1;
	assign q_push_data.vec  = $signed(vec_rd);
endmodule

// ===== rtl/cvm_back.sv =====
module cvm_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  cvm_pkg::op_t q_data,
	output logic         q_pop,
	cvm_stream_if.source result
);
	import cvm_pkg::*;

	logic                     p_valid_s2;
	logic                     p_last_s2;
	logic [ROW_W-1:0]         p_row_s2;
	logic signed [PROD_W-1:0] p_prod_s2;

	logic signed [PROD_W-1:0] mul;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     out_valid_q;
	result_t                  out_q;
	logic                     p_adv;

	// only a row end needs the output register free
	assign p_adv = p_valid_s2 && (!p_last_s2 || !out_valid_q || result.ready);
	assign q_pop = !q_empty && (!p_valid_s2 || p_adv);

	assign mul = PROD_W'(q_data.elem) * PROD_W'(q_data.vec);
	assign sum = acc_q + {{(SUM_W - PROD_W){p_prod_s2[PROD_W-1]}}, p_prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_valid_s2  <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				p_valid_s2 <= 1'b1;
			end else if (p_adv) begin
				p_valid_s2 <= 1'b0;
			end
			if (p_adv) begin
				if (p_last_s2) begin
					acc_q <= '0;
				end else begin
					acc_q <= sum;
				end
			end
			if (p_adv && p_last_s2) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			p_last_s2 <= q_data.last;
			p_row_s2  <= q_data.row;
			p_prod_s2 <= q_data.mac ? mul : '0;
		end
		if (p_adv && p_last_s2) begin
			out_q.out_row <= p_row_s2;
			out_q.row_sum <= sum;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;
endmodule

// ===== rtl/column_range_matrix_vector_mac_top.sv =====
// column slice matrix-vector multiply-accumulate
// item channel (sink): command 0 writes element_value into the vector store at
//   col_index; command 1 is a matrix element, streamed row-major
// result channel (source): one transfer per row, on the element at column
//   num_cols-1, carrying out_row and the Q17.30 partial sum over columns in
//   [start_col, end_col); the row accumulator then restarts at zero
// apb port: num_cols at 0x0, start_col at 0x4, end_col at 0x8, write only when idle
// throughput: one item per cycle while the queue has room, bounded by the single
//   multiply-accumulate path and the one read port of the vector store
// result path: front stage register, queue, product stage register, output register
// reset: registers return to their defaults and the accumulator clears;
//   the vector store keeps no reset and must be loaded before use
// receiver stall: the result is held in the output register; elements that do
//   not end a row keep accumulating, a row end waits, and the four-entry
//   queue fills before the item channel drops ready
module column_range_matrix_vector_mac_top #(
	parameter int MAX_COLS = cvm_pkg::MAX_COLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	cvm_stream_if.sink                 item,
	cvm_stream_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cvm_pkg::ADDR_W-1:0] paddr,
	input  logic [cvm_pkg::DATA_W-1:0] pwdata,
	output logic [cvm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import cvm_pkg::*;

	cfg_t              cfg_q;
	logic              wr;
	logic [ADDR_W-3:0] reg_sel;
	logic              q_push;
	op_t               q_push_data;
	logic              q_pop;
	op_t               q_pop_data;
	logic              q_empty;
	logic [LVL_W-1:0]  q_level;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_sel = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_cols  <= NUM_COLS_RST;
			cfg_q.start_col <= START_COL_RST;
			cfg_q.end_col   <= END_COL_RST;
		end else if (wr) begin
			unique case (reg_sel)
				REG_NUM_COLS:  cfg_q.num_cols  <= pwdata[CNT_W-1:0];
				REG_START_COL: cfg_q.start_col <= pwdata[COL_W-1:0];
				REG_END_COL:   cfg_q.end_col   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_NUM_COLS:  prdata = {{(DATA_W - CNT_W){1'b0}}, cfg_q.num_cols};
			REG_START_COL: prdata = {{(DATA_W - COL_W){1'b0}}, cfg_q.start_col};
			REG_END_COL:   prdata = {{(DATA_W - CNT_W){1'b0}}, cfg_q.end_col};
			default:       prdata = '0;
		endcase
	end

	cvm_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg         (cfg_q),
		.q_level     (q_level),
		.q_push      (q_push),
		.q_push_data (q_push_data)
	);

	cvm_fifo #(
		.item_t (op_t),
		.DEPTH  (QUEUE_DEPTH),
		.LW     (LVL_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty),
		.level     (q_level)
	);

	cvm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_pop_data),
		.q_pop   (q_pop),
		.result  (result)
	);
endmodule

// ===== rtl/cvm_checker.sv =====
module cvm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input cvm_pkg::result_t           result_data,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [cvm_pkg::ADDR_W-1:0] paddr,
	input logic [cvm_pkg::DATA_W-1:0] pwdata,
	input logic [cvm_pkg::DATA_W-1:0] prdata
);
	import cvm_pkg::*;

	// a stalled result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// input back-pressure only follows a stalled or pending result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid || $past(result_valid))
		else $error("item ready low without output back-pressure");

	// row length register reads back what was written
	a_num_cols_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_NUM_COLS)
		|=> (paddr[ADDR_W-1:2] != REG_NUM_COLS)
			|| (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0])))
		else $error("num_cols readback mismatch");
endmodule

bind column_range_matrix_vector_mac_top cvm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

// ===== bench/column_range_matrix_vector_mac_top_tb.sv =====
`timescale 1ns / 100ps

module column_range_matrix_vector_mac_top_tb;

	import cvm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	class row_sum_board;
		logic signed [VAL_W-1:0] vec_mem [COL_SPAN];
		bit                      vec_loaded [COL_SPAN];
		logic [CNT_W-1:0]        num_cols;
		logic [COL_W-1:0]        start_col;
		logic [CNT_W-1:0]        end_col;
		logic signed [SUM_W-1:0] acc;
		result_t                 rows_due [$];
		int                      errors;
		int                      rows_checked;
		int                      loads_seen;

		function new();
			num_cols     = NUM_COLS_RST;
			start_col    = START_COL_RST;
			end_col      = END_COL_RST;
			acc          = '0;
			errors       = 0;
			rows_checked = 0;
			loads_seen   = 0;
		endfunction

		function void set_reg(logic [ADDR_W-3:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_NUM_COLS:  num_cols = val[CNT_W-1:0];
				REG_START_COL: start_col = val[COL_W-1:0];
				REG_END_COL:   end_col = val[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit in_slice(logic [COL_W-1:0] col);
			return col >= start_col && {1'b0, col} < end_col;
		endfunction

		function void note_item(item_t it);
			logic signed [PROD_W-1:0] prod;
			result_t                  r;
			if (it.command == CMD_LOAD) begin
				vec_mem[it.col_index]    = it.element_value;
				vec_loaded[it.col_index] = 1'b1;
				loads_seen++;
				return;
			end
			if (in_slice(it.col_index)) begin
				prod = PROD_W'(it.element_value) * PROD_W'(vec_mem[it.col_index]);
				acc  = acc + SUM_W'(prod);
			end
			if (num_cols != '0 && {1'b0, it.col_index} == num_cols - CNT_W'(1)) begin
				r.out_row = it.row_index;
				r.row_sum = acc;
				rows_due.push_back(r);
				acc = '0;
			end
		endfunction

		function void check_row(result_t got);
			result_t want;
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row sum, row %0d sum %0d", $time, got.out_row,
					got.row_sum);
				errors++;
				return;
			end
			want = rows_due.pop_front();
			rows_checked++;
			if (got.out_row !== want.out_row) begin
				$display("%0t: out_row mismatch, expected %0d, actual %0d", $time,
					want.out_row, got.out_row);
				errors++;
			end
			if (got.row_sum !== want.row_sum) begin
				$display("%0t: row_sum mismatch on row %0d, expected %0d, actual %0d", $time,
					want.out_row, want.row_sum, got.row_sum);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	cvm_stream_if #(.payload_t(item_t))   item_ch ();
	cvm_stream_if #(.payload_t(result_t)) result_ch ();

	row_sum_board board = new();

	bit calm;
	bit hold_results;
	int items_sent;
	int settings_used;
	int cycle_count;

	column_range_matrix_vector_mac_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			board.note_item(item_ch.data);
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_row(result_ch.data);
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 24);
		if (calm || r < 15)
			return 0;
		if (r < 23)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'sh8000;
		if (r == 1)
			return 16'sh7fff;
		return VAL_W'($urandom);
	endfunction

	initial begin : result_sink
		int stall;
		stall           = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_ch.ready = 1'b0;
				repeat (120) @(negedge clk);
				hold_results = 1'b0;
			end else if (stall > 0) begin
				result_ch.ready = 1'b0;
				stall--;
			end else begin
				result_ch.ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = idle_span();
			end
		end
	end

	task automatic push_item(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
		logic signed [VAL_W-1:0] val);
		item_t it;
		int    gap;
		it.command       = cmd;
		it.row_index     = row;
		it.col_index     = col;
		it.element_value = val;
		gap = idle_span();
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.data  = it;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic load_vec(logic [COL_W-1:0] col, logic signed [VAL_W-1:0] val);
		push_item(CMD_LOAD, ROW_W'($urandom), col, val);
	endtask

	// a column in the slice is always loaded before the element that reads it
	task automatic send_elem(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
		logic signed [VAL_W-1:0] val);
		if (board.in_slice(col) && !board.vec_loaded[col])
			load_vec(col, pick_value());
		push_item(CMD_MATRIX, row, col, val);
	endtask

	task automatic apb_write(logic [ADDR_W-3:0] idx, logic [DATA_W-1:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		board.set_reg(idx, val);
	endtask

	task automatic set_slice(int nc, int sc, int ec);
		apb_write(REG_NUM_COLS, nc);
		apb_write(REG_START_COL, sc);
		apb_write(REG_END_COL, ec);
		settings_used++;
	endtask

	task automatic wait_drained();
		item_ch.valid = 1'b0;
		while (board.rows_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_row();
		logic [ROW_W-1:0] row;
		int               nc;
		int               r;
		row = ROW_W'($urandom);
		nc  = int'(board.num_cols);
		if (nc <= 64) begin
			for (int c = 0; c < nc; c++) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					load_vec(COL_W'($urandom_range(0, COL_SPAN - 1)), pick_value());
				else if (r < 11)
					send_elem(ROW_W'($urandom), COL_W'($urandom_range(0, COL_SPAN - 1)),
						pick_value());
				send_elem(row, COL_W'(c), pick_value());
			end
		end else begin
			repeat (4) send_elem(row, COL_W'($urandom_range(0, COL_SPAN - 1)), pick_value());
			send_elem(row, COL_W'(nc - 1), pick_value());
		end
	endtask

	initial begin : stimulus
		int nc;
		int sc;
		int ec;
		int pick;
		int target;

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		calm          = 1'b0;
		hold_results  = 1'b0;
		items_sent    = 0;
		settings_used = 1;
		cycle_count   = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full-width row at reset settings, extreme operands
		load_vec(12'd0, 16'sh7fff);
		load_vec(12'd1, 16'sh8000);
		load_vec(12'd2, 16'shffff);
		load_vec(12'd2048, 16'sh0001);
		load_vec(12'd4095, 16'sh8000);
		push_item(CMD_MATRIX, 12'hfff, 12'd0, 16'sh8000);
		push_item(CMD_MATRIX, 12'hfff, 12'd1, 16'sh8000);
		push_item(CMD_MATRIX, 12'hfff, 12'd2, 16'sh7fff);
		push_item(CMD_MATRIX, 12'hfff, 12'd4095, 16'sh8000);
		push_item(CMD_MATRIX, 12'h000, 12'd4095, 16'sh0000);

		// columns outside the slice, last one still ends the row
		wait_drained();
		set_slice(4, 1, 3);
		for (int c = 0; c < 4; c++)
			send_elem(12'h005, COL_W'(c), pick_value());

		// empty slice
		wait_drained();
		set_slice(1, 4095, 0);
		send_elem(12'h0aa, 12'd4095, 16'sh7fff);
		send_elem(12'h555, 12'd0, 16'sh8000);

		// no row end at length zero or beyond the store, sum carries over
		wait_drained();
		set_slice(0, 0, 4096);
		send_elem(12'h011, 12'd1, 16'sh8000);
		send_elem(12'h011, 12'd2, 16'sh1234);
		wait_drained();
		apb_write(REG_NUM_COLS, 8191);
		send_elem(12'h022, 12'd4095, 16'sh8000);
		wait_drained();
		apb_write(REG_NUM_COLS, 3);
		send_elem(12'h033, 12'd2, 16'sh7fff);

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			pick = $urandom_range(0, 9);
			if (p == 3)
				nc = $urandom_range(1, 3);
			else if (pick < 6)
				nc = $urandom_range(1, 12);
			else if (pick < 8)
				nc = $urandom_range(13, 40);
			else if (pick == 8)
				nc = 4096;
			else
				nc = 1;
			sc   = $urandom_range(0, nc - 1);
			pick = $urandom_range(0, 9);
			if (pick < 7)
				ec = $urandom_range(sc, nc);
			else if (pick == 7)
				ec = 4096;
			else if (pick == 8)
				ec = 0;
			else
				ec = sc;
			set_slice(nc, sc, ec);
			calm = (p == 3 || p == 6);
			if (p == 3)
				hold_results = 1'b1;
			target = items_sent + 62;
			while (items_sent < target)
				send_row();
		end
		calm = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d items (%0d vector loads) over %0d register settings, %0d row sums checked",
			items_sent, board.loads_seen, settings_used, board.rows_checked);
		if (board.errors == 0 && board.rows_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cvm_pkg.sv
rtl/cvm_stream_if.sv
rtl/cvm_ram.sv
rtl/cvm_fifo.sv
rtl/cvm_front.sv
rtl/cvm_back.sv
rtl/column_range_matrix_vector_mac_top.sv
rtl/cvm_checker.sv
bench/column_range_matrix_vector_mac_top_tb.sv
